// ===== src/scg_pkg.sv =====
package scg_pkg;

   localparam int VERTEX_W             = 7;
   localparam int DEG_W                = 2;
   localparam int DEFAULT_MAX_VERTICES = 64;
   localparam int REQ_DATA_W           = 16;
   localparam int RSP_DATA_W           = 16;

   localparam logic [DEG_W-1:0] DEG_NONE  = 2'd0;
   localparam logic [DEG_W-1:0] DEG_ONE   = 2'd1;
   localparam logic [DEG_W-1:0] DEG_CYCLE = 2'd2;
   localparam logic [DEG_W-1:0] DEG_SAT   = 2'd3;

   // one adjacency word per vertex: saturating degree and first two neighbors
   typedef struct packed {
      logic [DEG_W-1:0]    deg;
      logic [VERTEX_W-1:0] nb1;
      logic [VERTEX_W-1:0] nb2;
   } adj_entry_type;

   // append a neighbor; only the first two are kept
   function automatic adj_entry_type link_entry(input adj_entry_type ent,
                                                input logic [VERTEX_W-1:0] nb);
      adj_entry_type res;
      res = ent;
      if (ent.deg == DEG_NONE) begin
         res.nb1 = nb;
      end else if (ent.deg == DEG_ONE) begin
         res.nb2 = nb;
      end
      if (ent.deg != DEG_SAT) begin
         res.deg = ent.deg + DEG_ONE;
      end
      return res;
   endfunction

endpackage

// ===== src/simple_cycle_graph_check.sv =====
// An edge transaction passes through accept, update of the first endpoint and update of the second.
// The last edge then starts a walk from vertex 1 that reads, per visited vertex, its adjacency
// entry and then its neighbors' visited marks; a check/clear sweep and the output state follow.
// The block takes one transaction at a time; the walk is bound by the registered memory reads.
// Reset (synchronous, active high) starts a clear sweep over both memories; req_tready stays
// low until it ends.
module simple_cycle_graph_check #(
   parameter int MAX_VERTICES = scg_pkg::DEFAULT_MAX_VERTICES
) (
   input  logic                            clock,
   input  logic                            reset,
   // edge transactions
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // req_tdata: [6:0] vertex_a, [13:7] vertex_b, [15:14] zero
   input  logic [scg_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tlast,   // last_edge
   // result transactions
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // rsp_tdata: [0] is_simple_cycle, [7:1] vertex_count, [14:8] visited_count, [15] zero
   output logic [scg_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import scg_pkg::*;

   localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int CMP_W = (CNT_W > VERTEX_W) ? CNT_W : VERTEX_W;

   localparam logic [3:0] ST_CLEAR     = 4'd0;  // post-reset memory clear
   localparam logic [3:0] ST_IDLE      = 4'd1;
   localparam logic [3:0] ST_EDGE_A    = 4'd2;  // link a->b, read b
   localparam logic [3:0] ST_EDGE_B    = 4'd3;  // link b->a
   localparam logic [3:0] ST_WALK_INIT = 4'd4;  // mark vertex 1, read its entry
   localparam logic [3:0] ST_WALK_ADJ  = 4'd5;  // entry back, read both neighbor marks
   localparam logic [3:0] ST_WALK_SEL  = 4'd6;  // pick first unvisited neighbor
   localparam logic [3:0] ST_SWEEP     = 4'd7;  // degree check + clear
   localparam logic [3:0] ST_DONE      = 4'd8;

   function automatic logic [IDX_W-1:0] vidx(input logic [VERTEX_W-1:0] v);
      logic [VERTEX_W-1:0] m;
      m = v - VERTEX_W'(1);
      return IDX_W'(m);
   endfunction

   // state
   logic [3:0]          state_ff, state_in;
   logic [VERTEX_W-1:0] va_ff, va_in;
   logic [VERTEX_W-1:0] vb_ff, vb_in;
   logic                last_ff, last_in;
   logic                edge_ok_ff, edge_ok_in;
   logic [VERTEX_W-1:0] highest_ff, highest_in;
   adj_entry_type       a_new_ff, a_new_in;       // forwarded for self loops
   adj_entry_type       walk_ent_ff, walk_ent_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    sweep_idx_ff, sweep_idx_in;
   logic [CNT_W-1:0]    sweep_end_ff, sweep_end_in;
   logic                chk_ff, chk_in;
   logic                deg_ok_ff, deg_ok_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // memory ports
   logic [IDX_W-1:0] adj_rd_addr;
   adj_entry_type    adj_rd_data;
   logic             adj_wr_en;
   logic [IDX_W-1:0] adj_wr_addr;
   adj_entry_type    adj_wr_data;
   logic             vis_rd_data0;
   logic             vis_rd_data1;
   logic             vis_wr_en;
   logic [IDX_W-1:0] vis_wr_addr;
   logic             vis_wr_data;

   // input decode
   logic [VERTEX_W-1:0] req_a;
   logic [VERTEX_W-1:0] req_b;
   logic                req_ok;
   logic                req_fire;

   // walk selection
   logic                nb1_free;
   logic                nb2_free;
   logic                has_next;
   logic [VERTEX_W-1:0] next_v;
   logic                sweep_active;
   adj_entry_type       b_base;
   logic                cycle_ok;

   assign req_a    = req_tdata[VERTEX_W-1:0];
   assign req_b    = req_tdata[2*VERTEX_W-1:VERTEX_W];
   assign req_ok   = (req_a != '0) && (int'(req_a) <= MAX_VERTICES) &&
                     (req_b != '0) && (int'(req_b) <= MAX_VERTICES);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign nb1_free = (walk_ent_ff.deg != DEG_NONE) && !vis_rd_data0;
   assign nb2_free = (walk_ent_ff.deg >= DEG_CYCLE) && !vis_rd_data1;
   assign has_next = nb1_free || nb2_free;
   assign next_v   = nb1_free ? walk_ent_ff.nb1 : walk_ent_ff.nb2;

   assign sweep_active = (sweep_idx_ff < sweep_end_ff);
   assign b_base       = (va_ff == vb_ff) ? a_new_ff : adj_rd_data;
   assign cycle_ok     = deg_ok_ff && (CMP_W'(count_ff) == CMP_W'(highest_ff));

   always_comb begin
      state_in     = state_ff;
      va_in        = va_ff;
      vb_in        = vb_ff;
      last_in      = last_ff;
      edge_ok_in   = edge_ok_ff;
      highest_in   = highest_ff;
      a_new_in     = a_new_ff;
      walk_ent_in  = walk_ent_ff;
      count_in     = count_ff;
      sweep_idx_in = sweep_idx_ff;
      sweep_end_in = sweep_end_ff;
      chk_in       = chk_ff;
      deg_ok_in    = deg_ok_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      adj_rd_addr = '0;
      adj_wr_en   = 1'b0;
      adj_wr_addr = '0;
      adj_wr_data = '0;
      vis_wr_en   = 1'b0;
      vis_wr_addr = '0;
      vis_wr_data = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            adj_rd_addr = sweep_idx_ff[IDX_W-1:0];
            if (sweep_active) begin
               adj_wr_en    = 1'b1;
               adj_wr_addr  = sweep_idx_ff[IDX_W-1:0];
               vis_wr_en    = 1'b1;
               vis_wr_addr  = sweep_idx_ff[IDX_W-1:0];
               sweep_idx_in = sweep_idx_ff + CNT_W'(1);
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            adj_rd_addr = vidx(req_a);
            if (req_fire) begin
               va_in      = req_a;
               vb_in      = req_b;
               last_in    = req_tlast;
               edge_ok_in = req_ok;
               if (req_ok) begin
                  if (req_a > highest_in) highest_in = req_a;
                  if (req_b > highest_in) highest_in = req_b;
               end
               state_in = ST_EDGE_A;
            end
         end
         ST_EDGE_A: begin
            adj_rd_addr = vidx(vb_ff);
            a_new_in    = link_entry(adj_rd_data, vb_ff);
            adj_wr_en   = edge_ok_ff;
            adj_wr_addr = vidx(va_ff);
            adj_wr_data = a_new_in;
            state_in    = ST_EDGE_B;
         end
         ST_EDGE_B: begin
            adj_wr_en   = edge_ok_ff;
            adj_wr_addr = vidx(vb_ff);
            adj_wr_data = link_entry(b_base, va_ff);
            state_in    = last_ff ? ST_WALK_INIT : ST_IDLE;
         end
         ST_WALK_INIT: begin
            adj_rd_addr = '0;
            vis_wr_en   = 1'b1;
            vis_wr_addr = '0;
            vis_wr_data = 1'b1;
            count_in    = CNT_W'(1);
            state_in    = ST_WALK_ADJ;
         end
         ST_WALK_ADJ: begin
            walk_ent_in = adj_rd_data;
            state_in    = ST_WALK_SEL;
         end
         ST_WALK_SEL: begin
            if (has_next) begin
               adj_rd_addr = vidx(next_v);
               vis_wr_en   = 1'b1;
               vis_wr_addr = vidx(next_v);
               vis_wr_data = 1'b1;
               count_in    = count_ff + CNT_W'(1);
               state_in    = ST_WALK_ADJ;
            end else begin
               sweep_idx_in = '0;
               sweep_end_in = CNT_W'(highest_ff);
               chk_in       = 1'b0;
               deg_ok_in    = 1'b1;
               state_in     = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            // read and clear entry i, check its degree in the following cycle
            adj_rd_addr = sweep_idx_ff[IDX_W-1:0];
            chk_in      = sweep_active;
            if (chk_ff && (adj_rd_data.deg != DEG_CYCLE)) begin
               deg_ok_in = 1'b0;
            end
            if (sweep_active) begin
               adj_wr_en    = 1'b1;
               adj_wr_addr  = sweep_idx_ff[IDX_W-1:0];
               vis_wr_en    = 1'b1;
               vis_wr_addr  = sweep_idx_ff[IDX_W-1:0];
               sweep_idx_in = sweep_idx_ff + CNT_W'(1);
            end else if (!chk_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, VERTEX_W'(count_ff), highest_ff, cycle_ok};
               highest_in   = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         highest_ff   <= '0;
         sweep_idx_ff <= '0;
         sweep_end_ff <= CNT_W'(MAX_VERTICES);
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         highest_ff   <= highest_in;
         sweep_idx_ff <= sweep_idx_in;
         sweep_end_ff <= sweep_end_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      va_ff       <= va_in;
      vb_ff       <= vb_in;
      last_ff     <= last_in;
      edge_ok_ff  <= edge_ok_in;
      a_new_ff    <= a_new_in;
      walk_ent_ff <= walk_ent_in;
      count_ff    <= count_in;
      deg_ok_ff   <= deg_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   scg_store #(
      .MAX_VERTICES (MAX_VERTICES),
      .IDX_W        (IDX_W)
   ) u_store (
      .clock        (clock),
      .adj_rd_addr  (adj_rd_addr),
      .adj_rd_data  (adj_rd_data),
      .adj_wr_en    (adj_wr_en),
      .adj_wr_addr  (adj_wr_addr),
      .adj_wr_data  (adj_wr_data),
      .vis_rd_addr0 (vidx(adj_rd_data.nb1)),
      .vis_rd_addr1 (vidx(adj_rd_data.nb2)),
      .vis_rd_data0 (vis_rd_data0),
      .vis_rd_data1 (vis_rd_data1),
      .vis_wr_en    (vis_wr_en),
      .vis_wr_addr  (vis_wr_addr),
      .vis_wr_data  (vis_wr_data)
   );

endmodule

// ===== src/scg_store.sv =====
module scg_store #(
   parameter int MAX_VERTICES = scg_pkg::DEFAULT_MAX_VERTICES,
   parameter int IDX_W        = $clog2(MAX_VERTICES)
) (
   input  logic                  clock,
   // adjacency memory: one read, one write
   input  logic [IDX_W-1:0]      adj_rd_addr,
   output scg_pkg::adj_entry_type adj_rd_data,
   input  logic                  adj_wr_en,
   input  logic [IDX_W-1:0]      adj_wr_addr,
   input  scg_pkg::adj_entry_type adj_wr_data,
   // visited marks: two reads, one write
   input  logic [IDX_W-1:0]      vis_rd_addr0,
   input  logic [IDX_W-1:0]      vis_rd_addr1,
   output logic                  vis_rd_data0,
   output logic                  vis_rd_data1,
   input  logic                  vis_wr_en,
   input  logic [IDX_W-1:0]      vis_wr_addr,
   input  logic                  vis_wr_data
);
   import scg_pkg::*;

   adj_entry_type adj_mem [MAX_VERTICES];
   logic          vis_mem [MAX_VERTICES];

   adj_entry_type adj_rd_data_ff;
   logic          vis_rd_data0_ff;
   logic          vis_rd_data1_ff;

   // read-before-write on a same-address collision
   always_ff @(posedge clock) begin
      adj_rd_data_ff <= adj_mem[adj_rd_addr];
      if (adj_wr_en) begin
         adj_mem[adj_wr_addr] <= adj_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      vis_rd_data0_ff <= vis_mem[vis_rd_addr0];
      vis_rd_data1_ff <= vis_mem[vis_rd_addr1];
      if (vis_wr_en) begin
         vis_mem[vis_wr_addr] <= vis_wr_data;
      end
   end

   assign adj_rd_data  = adj_rd_data_ff;
   assign vis_rd_data0 = vis_rd_data0_ff;
   assign vis_rd_data1 = vis_rd_data1_ff;

endmodule

// ===== sim/simple_cycle_graph_check_monitor.sv =====
module simple_cycle_graph_check_monitor (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [scg_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tlast,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [scg_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                             mismatch_count,
   output int                             verdicts_pending
);
   import scg_pkg::*;

   localparam int VERTICES = DEFAULT_MAX_VERTICES;

   typedef struct packed {
      logic                is_cycle;
      logic [VERTEX_W-1:0] vertex_count;
      logic [VERTEX_W-1:0] visited_count;
   } verdict_type;

   // shadow adjacency of the graph being loaded
   logic [DEG_W-1:0]    degree    [1:VERTICES];
   logic [VERTEX_W-1:0] nb_first  [1:VERTICES];
   logic [VERTEX_W-1:0] nb_second [1:VERTICES];
   logic [VERTEX_W-1:0] top_vertex;
   verdict_type         expected_verdicts [$];

   task automatic clear_graph();
      for (int i = 1; i <= VERTICES; i++) begin
         degree[i] = DEG_NONE;
      end
      top_vertex = '0;
   endtask

   task automatic attach(input int v, input logic [VERTEX_W-1:0] nb);
      if (degree[v] == DEG_NONE) begin
         nb_first[v] = nb;
      end else if (degree[v] == DEG_ONE) begin
         nb_second[v] = nb;
      end
      if (degree[v] != DEG_SAT) begin
         degree[v] = degree[v] + DEG_ONE;
      end
   endtask

   // greedy walk from vertex 1, then the degree-two check over 1..top_vertex
   function automatic verdict_type judge_graph();
      bit          seen [1:VERTICES];
      int          here;
      int          step_to;
      int          walked;
      verdict_type v;
      seen = '{default: 1'b0};
      here = 1;
      walked = 1;
      seen[1] = 1'b1;
      for (int step = 0; step < VERTICES; step++) begin
         step_to = 0;
         if (degree[here] != DEG_NONE && !seen[nb_first[here]]) begin
            step_to = nb_first[here];
         end else if (degree[here] >= DEG_CYCLE && !seen[nb_second[here]]) begin
            step_to = nb_second[here];
         end
         if (step_to == 0) break;
         here = step_to;
         seen[here] = 1'b1;
         walked++;
      end
      v.is_cycle = (walked == int'(top_vertex));
      for (int i = 1; i <= int'(top_vertex); i++) begin
         if (degree[i] != DEG_CYCLE) v.is_cycle = 1'b0;
      end
      v.vertex_count  = top_vertex;
      v.visited_count = VERTEX_W'(walked);
      return v;
   endfunction

   task automatic absorb_edge(input logic [VERTEX_W-1:0] a, input logic [VERTEX_W-1:0] b,
                              input logic last);
      if (a >= 1 && a <= VERTICES && b >= 1 && b <= VERTICES) begin
         if (a > top_vertex) top_vertex = a;
         if (b > top_vertex) top_vertex = b;
         attach(a, b);
         attach(b, a);
      end
      if (last) begin
         expected_verdicts.push_back(judge_graph());
         clear_graph();
      end
   endtask

   always @(posedge clock) begin
      verdict_type got;
      verdict_type want;
      if (reset) begin
         clear_graph();
         expected_verdicts.delete();
         mismatch_count = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            absorb_edge(req_tdata[VERTEX_W-1:0], req_tdata[2*VERTEX_W-1:VERTEX_W], req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.is_cycle      = rsp_tdata[0];
            got.vertex_count  = rsp_tdata[VERTEX_W:1];
            got.visited_count = rsp_tdata[2*VERTEX_W:VERTEX_W+1];
            if (expected_verdicts.size() == 0) begin
               $error("unexpected result transaction: tdata %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_verdicts.pop_front();
               if (got.is_cycle !== want.is_cycle) begin
                  $error("is_simple_cycle: expected %0d, got %0d", want.is_cycle, got.is_cycle);
                  mismatch_count++;
               end
               if (got.vertex_count !== want.vertex_count) begin
                  $error("vertex_count: expected %0d, got %0d",
                         want.vertex_count, got.vertex_count);
                  mismatch_count++;
               end
               if (got.visited_count !== want.visited_count) begin
                  $error("visited_count: expected %0d, got %0d",
                         want.visited_count, got.visited_count);
                  mismatch_count++;
               end
            end
         end
      end
      verdicts_pending = expected_verdicts.size();
   end

endmodule

// ===== sim/simple_cycle_graph_check_tb.sv =====
module simple_cycle_graph_check_tb;
   import scg_pkg::*;

   localparam int VERTICES     = DEFAULT_MAX_VERTICES;
   localparam int TOP_CODE     = 2**VERTEX_W - 1;   // largest value a vertex field holds
   localparam int RANDOM_ITEMS = 400;
   localparam int LONG_HOLD    = 400;               // receiver hold-off, in cycles
   localparam int DRAIN_CYCLES = 300;               // > worst walk + sweep of a 64-vertex graph

   // shapes of random graphs
   typedef enum int {
      RING_CLOSED,   // one cycle over 1..n: the yes case
      RING_OPEN,     // cycle with one edge missing
      RING_CHORD,    // cycle plus one extra edge
      RING_SPLIT,    // two disjoint cycles
      RING_STRAY,    // cycle plus an out-of-range edge somewhere
      EDGE_NOISE     // arbitrary endpoints
   } graph_kind_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int   send_idle_pct = 20;
   int   recv_idle_pct = 76;
   logic hold_toggle   = 1'b0;   // flipped by stimulus to request a long hold-off
   logic hold_seen     = 1'b0;
   int   hold_left     = 0;
   int   mismatch_count;
   int   verdicts_pending;
   int   items_sent    = 0;      // transactions the block does not simply ignore

   logic [VERTEX_W-1:0] edge_a [$];
   logic [VERTEX_W-1:0] edge_b [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   simple_cycle_graph_check dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   simple_cycle_graph_check_monitor u_monitor (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tlast        (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .mismatch_count   (mismatch_count),
      .verdicts_pending (verdicts_pending)
   );

   // Receiver: random backpressure; a flip of hold_toggle starts a long
   // hold-off counted here, so the block backs up into the edge channel.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
      end else if (hold_toggle != hold_seen) begin
         hold_seen  <= hold_toggle;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // One edge transaction; returns at the edge where it is accepted.
   // tvalid stays high into the next call unless that call idles.
   task automatic send_edge(input logic [VERTEX_W-1:0] a, input logic [VERTEX_W-1:0] b,
                            input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-2*VERTEX_W){1'b0}}, b, a};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      if ((a >= 1 && a <= VERTICES && b >= 1 && b <= VERTICES) || last) items_sent++;
   endtask

   // Sender pause until every predicted verdict has come back. Checked on
   // the falling edge so the checker's update at the rising edge is settled.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (verdicts_pending != 0);
      @(posedge clock);
   endtask

   function automatic logic [VERTEX_W-1:0] rogue_vertex();
      return ($urandom_range(1) == 0) ? '0 : VERTEX_W'($urandom_range(TOP_CODE, VERTICES + 1));
   endfunction

   task automatic add_ring(input int members [$]);
      for (int i = 0; i < members.size(); i++) begin
         edge_a.push_back(VERTEX_W'(members[i]));
         edge_b.push_back(VERTEX_W'(members[(i + 1) % members.size()]));
      end
   endtask

   // Shuffle the collected edges, flip endpoints at random, mark the final
   // transaction as last.
   task automatic send_edge_list();
      int                  j;
      logic [VERTEX_W-1:0] t;
      for (int i = edge_a.size() - 1; i > 0; i--) begin
         j = $urandom_range(i);
         t = edge_a[i]; edge_a[i] = edge_a[j]; edge_a[j] = t;
         t = edge_b[i]; edge_b[i] = edge_b[j]; edge_b[j] = t;
      end
      for (int i = 0; i < edge_a.size(); i++) begin
         if ($urandom_range(1) == 0) begin
            send_edge(edge_a[i], edge_b[i], i == edge_a.size() - 1);
         end else begin
            send_edge(edge_b[i], edge_a[i], i == edge_a.size() - 1);
         end
      end
      edge_a.delete();
      edge_b.delete();
   endtask

   task automatic send_graph(input graph_kind_type kind, input int n);
      int order [$];
      int part  [$];
      int j;
      int t;
      int k;
      for (int v = 1; v <= n; v++) order.push_back(v);
      for (int i = n - 1; i > 0; i--) begin
         j = $urandom_range(i);
         t = order[i]; order[i] = order[j]; order[j] = t;
      end
      case (kind)
         RING_SPLIT: begin
            k = $urandom_range(n - 2, 2);
            for (int i = 0; i < k; i++) part.push_back(order[i]);
            add_ring(part);
            part.delete();
            for (int i = k; i < n; i++) part.push_back(order[i]);
            add_ring(part);
         end
         EDGE_NOISE: begin
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(7) == 0) begin
                  edge_a.push_back(VERTEX_W'($urandom_range(TOP_CODE)));
                  edge_b.push_back(VERTEX_W'($urandom_range(TOP_CODE)));
               end else begin
                  edge_a.push_back(VERTEX_W'($urandom_range(n, 1)));
                  edge_b.push_back(VERTEX_W'($urandom_range(n, 1)));
               end
            end
         end
         default: begin
            add_ring(order);
            if (kind == RING_OPEN) begin
               j = $urandom_range(edge_a.size() - 1);
               edge_a.delete(j);
               edge_b.delete(j);
            end else if (kind == RING_CHORD) begin
               edge_a.push_back(VERTEX_W'(order[$urandom_range(n - 1)]));
               edge_b.push_back(VERTEX_W'(order[$urandom_range(n - 1)]));
            end else if (kind == RING_STRAY) begin
               edge_a.push_back(rogue_vertex());
               edge_b.push_back(VERTEX_W'($urandom_range(TOP_CODE)));
            end
         end
      endcase
      send_edge_list();
   endtask

   initial begin
      int             base;
      int             pick;
      int             n;
      graph_kind_type kind;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: two graphs with no valid edge, ignored endpoints 0 and 127
      send_edge(7'd0, 7'd5, 1'b1);
      send_edge(7'd127, 7'd64, 1'b1);
      // smallest cycles: a self loop, two parallel edges, a triangle
      send_edge(7'd1, 7'd1, 1'b1);
      send_edge(7'd1, 7'd2, 1'b0);
      send_edge(7'd2, 7'd1, 1'b1);
      send_edge(7'd1, 7'd2, 1'b0);
      send_edge(7'd2, 7'd3, 1'b0);
      send_edge(7'd3, 7'd1, 1'b1);
      // degree above two at vertex 1: the walk never takes its later neighbors
      send_edge(7'd1, 7'd2, 1'b0);
      send_edge(7'd1, 7'd3, 1'b0);
      send_edge(7'd1, 7'd4, 1'b0);
      send_edge(7'd2, 7'd3, 1'b1);
      // ignored edge mid-graph, highest vertex number
      send_edge(7'd65, 7'd3, 1'b0);
      send_edge(7'd64, 7'd1, 1'b0);
      send_edge(7'd1, 7'd64, 1'b1);
      // self loop on top of another edge saturates the degree
      send_edge(7'd1, 7'd2, 1'b0);
      send_edge(7'd2, 7'd2, 1'b1);
      wait_drained();

      base = items_sent;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct <= (phase == 0) ? 20 : (phase == 1) ? 76 : 0;
         recv_idle_pct <= (phase == 0) ? 76 : (phase == 1) ? 20 : 0;
         // with no idling the receiver first blocks for a long stretch
         if (phase == 2) hold_toggle <= ~hold_toggle;
         while (items_sent < base + (phase + 1) * RANDOM_ITEMS / 3) begin
            pick = $urandom_range(99);
            kind = (pick < 50) ? RING_CLOSED :
                   (pick < 60) ? RING_OPEN   :
                   (pick < 68) ? RING_CHORD  :
                   (pick < 76) ? RING_SPLIT  :
                   (pick < 84) ? RING_STRAY  : EDGE_NOISE;
            // mostly small graphs; now and then the full vertex range
            if ($urandom_range(29) == 0) begin
               n = VERTICES;
            end else if (kind == RING_SPLIT) begin
               n = $urandom_range(12, 4);
            end else if (kind == RING_CLOSED || kind == EDGE_NOISE) begin
               n = $urandom_range(12, 1);
            end else begin
               n = $urandom_range(12, 3);
            end
            send_graph(kind, n);
            if ($urandom_range(9) == 0) wait_drained();
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // hard stop far beyond the slowest correct run
   initial begin
      #5000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== simple_cycle_graph_check.f =====
src/scg_pkg.sv
src/scg_store.sv
src/simple_cycle_graph_check.sv
sim/simple_cycle_graph_check_monitor.sv
sim/simple_cycle_graph_check_tb.sv
